>>> sv/aar_pkg.sv
// Shared constants, types and small constant tables for the axis-angle
// rotation matrix pipeline. No dependencies.
`timescale 1ns / 1ps
package aar_pkg;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 31;
	localparam int SER_TERMS  = 6;
	localparam int SER_SHIFT  = 36;

	// abs/max, shift, squares, sum, root, numerator, divide, sign
	localparam int NORM_LAT = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;
	// reduce, quadrant, multiply, round, square, round, terms, finish
	localparam int SC_LAT   = 6 + 3 * SER_TERMS + 1;
	localparam int ANG_DLY  = NORM_LAT - SC_LAT;

	localparam logic [25:0] TURN_U    = 26'd47185920;
	localparam logic [25:0] QUARTER_U = 26'd11796480;
	localparam logic [25:0] EIGHTH_U  = 26'd5898240;

	localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
	localparam logic [63:0] DEG2RAD_Q46 = (PI_Q60 + 64'd1474560) / 64'd2949120;
	localparam logic [63:0] RECIP_BASE  = 64'd1 << SER_SHIFT;

	localparam logic [31:0] ONE30_U     = 32'd1 << 30;
	localparam logic signed [63:0] ONE60 = 64'sd1 <<< 60;

	typedef struct packed {
		logic             vld;
		logic             ok;
		logic [2:0][31:0] u;
	} aar_unit_t;

	// Taylor divisor n(n+1) for term k; sine lane uses n = 2k+2, cosine n = 2k+1
	function automatic logic [7:0] ser_div(input logic cos_lane, input logic [2:0] k);
		logic [7:0] d;
		d = 8'd0;
		if (cos_lane) begin
			case (k)
				3'd0: d = 8'd2;
				3'd1: d = 8'd12;
				3'd2: d = 8'd30;
				3'd3: d = 8'd56;
				3'd4: d = 8'd90;
				default: d = 8'd132;
			endcase
		end else begin
			case (k)
				3'd0: d = 8'd6;
				3'd1: d = 8'd20;
				3'd2: d = 8'd42;
				3'd3: d = 8'd72;
				3'd4: d = 8'd110;
				default: d = 8'd156;
			endcase
		end
		return d;
	endfunction

	// floor(2^36 / divisor), for the reciprocal multiply
	function automatic logic [35:0] ser_mul(input logic cos_lane, input logic [2:0] k);
		logic [63:0] m;
		m = 64'd0;
		if (cos_lane) begin
			case (k)
				3'd0: m = RECIP_BASE / 64'd2;
				3'd1: m = RECIP_BASE / 64'd12;
				3'd2: m = RECIP_BASE / 64'd30;
				3'd3: m = RECIP_BASE / 64'd56;
				3'd4: m = RECIP_BASE / 64'd90;
				default: m = RECIP_BASE / 64'd132;
			endcase
		end else begin
			case (k)
				3'd0: m = RECIP_BASE / 64'd6;
				3'd1: m = RECIP_BASE / 64'd20;
				3'd2: m = RECIP_BASE / 64'd42;
				3'd3: m = RECIP_BASE / 64'd72;
				3'd4: m = RECIP_BASE / 64'd110;
				default: m = RECIP_BASE / 64'd156;
			endcase
		end
		return m[35:0];
	endfunction

endpackage

>>> sv/aar_norm.sv
// Axis normalization pipeline: abs/max, shift, sum of squares, bit-per-stage
// square root and three bit-per-stage dividers. Depends on aar_pkg.
`timescale 1ns / 1ps
module aar_norm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld,
	input  logic [2:0][31:0] axis,
	output aar_pkg::aar_unit_t res
);

	logic [2:0][31:0] mag_c;
	logic [31:0]      mx_c;
	logic [4:0]       sh_c;

	logic [2:0][31:0] mag_s1;
	logic [2:0]       neg_s1;
	logic [31:0]      mx_s1;
	logic             vld_s1;

	logic [2:0][31:0] mag_s2;
	logic [2:0]       neg_s2;
	logic             ok_s2;
	logic             vld_s2;

	logic [2:0][63:0] sq_s3;
	logic [2:0][31:0] mag_s3;
	logic [2:0]       neg_s3;
	logic             ok_s3;
	logic             vld_s3;

	// index 0 is stage 4 (sum of squares), one index per root bit
	logic [63:0]      rt_rem_s  [0:aar_pkg::SQRT_STEPS];
	logic [31:0]      rt_root_s [0:aar_pkg::SQRT_STEPS];
	logic [2:0][31:0] rt_mag_s  [0:aar_pkg::SQRT_STEPS];
	logic [2:0]       rt_neg_s  [0:aar_pkg::SQRT_STEPS];
	logic             rt_ok_s   [0:aar_pkg::SQRT_STEPS];
	logic             rt_vld_s  [0:aar_pkg::SQRT_STEPS];

	// index 0 is the numerator stage, one index per quotient bit
	logic [2:0][61:0] dv_rem_s [0:aar_pkg::DIV_STEPS];
	logic [2:0][30:0] dv_quo_s [0:aar_pkg::DIV_STEPS];
	logic [31:0]      dv_r_s   [0:aar_pkg::DIV_STEPS];
	logic [2:0]       dv_neg_s [0:aar_pkg::DIV_STEPS];
	logic             dv_ok_s  [0:aar_pkg::DIV_STEPS];
	logic             dv_vld_s [0:aar_pkg::DIV_STEPS];

	logic [2:0][31:0] u_s69;
	logic             ok_s69;
	logic             vld_s69;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = axis[i][31] ? (~axis[i] + 32'd1) : axis[i];
		end
		mx_c = mag_c[0];
		if (mag_c[1] > mx_c) mx_c = mag_c[1];
		if (mag_c[2] > mx_c) mx_c = mag_c[2];
	end

	// shift that brings the largest magnitude into [2^30, 2^31]
	always_comb begin
		sh_c = 5'd0;
		for (int b = 0; b < 31; b++) begin
			if (mx_s1[b]) sh_c = 5'(30 - b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			rt_vld_s[0] <= 1'b0;
			dv_vld_s[0] <= 1'b0;
			vld_s69     <= 1'b0;
		end else if (en) begin
			vld_s1      <= vld;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			rt_vld_s[0] <= vld_s3;
			dv_vld_s[0] <= rt_vld_s[aar_pkg::SQRT_STEPS];
			vld_s69     <= dv_vld_s[aar_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_c;
			neg_s1 <= {axis[2][31], axis[1][31], axis[0][31]};
			mx_s1  <= mx_c;

			for (int i = 0; i < 3; i++) begin
				mag_s2[i] <= mag_s1[i] << sh_c;
			end
			neg_s2 <= neg_s1;
			ok_s2  <= (mx_s1 != 32'd0);

			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= 64'(mag_s2[i]) * 64'(mag_s2[i]);
			end
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			ok_s3  <= ok_s2;

			rt_rem_s[0]  <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			rt_root_s[0] <= 32'd0;
			rt_mag_s[0]  <= mag_s3;
			rt_neg_s[0]  <= neg_s3;
			rt_ok_s[0]   <= ok_s3;

			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= {rt_mag_s[aar_pkg::SQRT_STEPS][i], 30'd0}
					+ 62'(rt_root_s[aar_pkg::SQRT_STEPS] >> 1);
				dv_quo_s[0][i] <= 31'd0;
			end
			dv_r_s[0]   <= rt_root_s[aar_pkg::SQRT_STEPS];
			dv_neg_s[0] <= rt_neg_s[aar_pkg::SQRT_STEPS];
			dv_ok_s[0]  <= rt_ok_s[aar_pkg::SQRT_STEPS];
		end
	end

	for (genvar k = 0; k < aar_pkg::SQRT_STEPS; k++) begin : g_sqrt
		localparam int B = aar_pkg::SQRT_STEPS - 1 - k;
		logic [65:0] cand;
		logic        take;

		always_comb begin
			cand = ({34'd0, rt_root_s[k]} << (B + 1)) + (66'd1 << (2 * B));
			take = ({2'b00, rt_rem_s[k]} >= cand);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				rt_vld_s[k+1] <= rt_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_s[k+1]  <= take ? (rt_rem_s[k] - cand[63:0]) : rt_rem_s[k];
				rt_root_s[k+1] <= take ? (rt_root_s[k] | (32'd1 << B)) : rt_root_s[k];
				rt_mag_s[k+1]  <= rt_mag_s[k];
				rt_neg_s[k+1]  <= rt_neg_s[k];
				rt_ok_s[k+1]   <= rt_ok_s[k];
			end
		end
	end

	for (genvar k = 0; k < aar_pkg::DIV_STEPS; k++) begin : g_div
		localparam int B = aar_pkg::DIV_STEPS - 1 - k;
		logic [61:0] cand;
		logic [2:0]  take;

		always_comb begin
			cand = {30'd0, dv_r_s[k]} << B;
			for (int i = 0; i < 3; i++) begin
				take[i] = (dv_rem_s[k][i] >= cand);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[k+1][i] <= take[i] ? (dv_rem_s[k][i] - cand) : dv_rem_s[k][i];
					dv_quo_s[k+1][i] <= take[i] ? (dv_quo_s[k][i] | (31'd1 << B))
						: dv_quo_s[k][i];
				end
				dv_r_s[k+1]   <= dv_r_s[k];
				dv_neg_s[k+1] <= dv_neg_s[k];
				dv_ok_s[k+1]  <= dv_ok_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic [31:0] v;
				v = {1'b0, dv_quo_s[aar_pkg::DIV_STEPS][i]};
				if (v > aar_pkg::ONE30_U) v = aar_pkg::ONE30_U;
				u_s69[i] <= dv_neg_s[aar_pkg::DIV_STEPS][i] ? (~v + 32'd1) : v;
			end
			ok_s69 <= dv_ok_s[aar_pkg::DIV_STEPS];
		end
	end

	assign res.vld = vld_s69;
	assign res.ok  = ok_s69;
	assign res.u   = u_s69;

endmodule

>>> sv/aar_sincos.sv
// Half-angle sine and cosine pipeline: range reduction, degrees to radians,
// Taylor terms with reciprocal-multiply division. Depends on aar_pkg.
`timescale 1ns / 1ps
module aar_sincos (
	input  logic               clk,
	input  logic               en,
	input  logic signed [25:0] angle,
	output logic signed [31:0] sn,
	output logic signed [31:0] cs
);

	localparam int NOFF = 3 * aar_pkg::SER_TERMS;

	logic [25:0] h_s1;
	logic [1:0]  quad_s2;
	logic [22:0] rem_s2;
	logic        swap_s2;
	logic [63:0] pr_s3;
	logic [1:0]  quad_s3;
	logic        swap_s3;
	logic [31:0] xr_s4;
	logic [1:0]  quad_s4;
	logic        swap_s4;
	logic [63:0] xx_s5;
	logic [31:0] xr_s5;
	logic [1:0]  quad_s5;
	logic        swap_s5;

	// side data, index 0 is stage 6, then one index per term stage
	logic [31:0] x2_s   [0:NOFF];
	logic [1:0]  quad_s [0:NOFF];
	logic        swap_s [0:NOFF];

	// per lane (0 sine, 1 cosine): term and partial sum at term boundaries
	logic [32:0]        t_s   [0:1][0:aar_pkg::SER_TERMS];
	logic signed [34:0] sum_s [0:1][0:aar_pkg::SER_TERMS];

	logic signed [31:0] sn_s25;
	logic signed [31:0] cs_s25;

	logic [1:0]  quad_c;
	logic [23:0] rraw_c;
	logic [30:0] lane_v [0:1];

	always_comb begin
		if (h_s1 >= 26'(3 * aar_pkg::QUARTER_U)) begin
			quad_c = 2'd3;
			rraw_c = 24'(h_s1 - 26'(3 * aar_pkg::QUARTER_U));
		end else if (h_s1 >= 26'(2 * aar_pkg::QUARTER_U)) begin
			quad_c = 2'd2;
			rraw_c = 24'(h_s1 - 26'(2 * aar_pkg::QUARTER_U));
		end else if (h_s1 >= aar_pkg::QUARTER_U) begin
			quad_c = 2'd1;
			rraw_c = 24'(h_s1 - aar_pkg::QUARTER_U);
		end else begin
			quad_c = 2'd0;
			rraw_c = h_s1[23:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// angle magnitude stays below one turn, so one add wraps it
			h_s1 <= angle[25] ? 26'(27'(angle) + 27'(aar_pkg::TURN_U)) : 26'(angle);

			quad_s2 <= quad_c;
			if (rraw_c > 24'(aar_pkg::EIGHTH_U)) begin
				rem_s2  <= 23'(24'(aar_pkg::QUARTER_U) - rraw_c);
				swap_s2 <= 1'b1;
			end else begin
				rem_s2  <= rraw_c[22:0];
				swap_s2 <= 1'b0;
			end

			pr_s3   <= {41'd0, rem_s2} * {23'd0, aar_pkg::DEG2RAD_Q46[40:0]};
			quad_s3 <= quad_s2;
			swap_s3 <= swap_s2;

			xr_s4   <= 32'((pr_s3 + (64'd1 << 30)) >> 31);
			quad_s4 <= quad_s3;
			swap_s4 <= swap_s3;

			xx_s5   <= 64'(xr_s4) * 64'(xr_s4);
			xr_s5   <= xr_s4;
			quad_s5 <= quad_s4;
			swap_s5 <= swap_s4;

			x2_s[0]     <= 32'((xx_s5 + (64'd1 << 31)) >> 32);
			quad_s[0]   <= quad_s5;
			swap_s[0]   <= swap_s5;
			t_s[0][0]   <= {1'b0, xr_s5};
			sum_s[0][0] <= 35'(xr_s5);
			t_s[1][0]   <= 33'd1 << 32;
			sum_s[1][0] <= 35'sd1 <<< 32;

			for (int j = 1; j <= NOFF; j++) begin
				x2_s[j]   <= x2_s[j-1];
				quad_s[j] <= quad_s[j-1];
				swap_s[j] <= swap_s[j-1];
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		for (genvar k = 0; k < aar_pkg::SER_TERMS; k++) begin : g_term
			localparam logic [7:0]  D = aar_pkg::ser_div(l == 1, 3'(k));
			localparam logic [35:0] M = aar_pkg::ser_mul(l == 1, 3'(k));

			logic [31:0]        p_sa;
			logic signed [34:0] sum_sa;
			logic [31:0]        p_sb;
			logic [31:0]        q_sb;
			logic signed [34:0] sum_sb;
			logic [64:0]        tx;
			logic [67:0]        pm;
			logic [39:0]        qd;
			logic [32:0]        r;
			logic [32:0]        tq;

			always_comb begin
				tx = 65'(t_s[l][k]) * 65'(x2_s[3*k]);
				pm = 68'(p_sa) * 68'(M);
				qd = 40'(q_sb) * 40'(D);
				r  = {1'b0, p_sb} - qd[32:0];
				// estimate is low by at most one
				tq = (r >= 33'(D)) ? (33'(q_sb) + 33'd1) : 33'(q_sb);
			end

			always_ff @(posedge clk) begin
				if (en) begin
					p_sa   <= tx[63:32];
					sum_sa <= sum_s[l][k];

					p_sb   <= p_sa;
					q_sb   <= 32'(pm >> aar_pkg::SER_SHIFT);
					sum_sb <= sum_sa;

					t_s[l][k+1]   <= tq;
					sum_s[l][k+1] <= (k % 2 == 0) ? (sum_sb - 35'(tq)) : (sum_sb + 35'(tq));
				end
			end
		end

		always_comb begin
			logic signed [34:0] v;
			v = sum_s[l][aar_pkg::SER_TERMS];
			if (v < 35'sd0) v = 35'sd0;
			if (v > (35'sd1 <<< 32)) v = 35'sd1 <<< 32;
			lane_v[l] = 31'((v + 35'sd2) >>> 2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [31:0] s;
			logic signed [31:0] c;
			s = swap_s[NOFF] ? 32'(lane_v[1]) : 32'(lane_v[0]);
			c = swap_s[NOFF] ? 32'(lane_v[0]) : 32'(lane_v[1]);
			case (quad_s[NOFF])
				2'd0: begin
					sn_s25 <= s;
					cs_s25 <= c;
				end
				2'd1: begin
					sn_s25 <= c;
					cs_s25 <= -s;
				end
				2'd2: begin
					sn_s25 <= -s;
					cs_s25 <= -c;
				end
				default: begin
					sn_s25 <= -c;
					cs_s25 <= s;
				end
			endcase
		end
	end

	assign sn = sn_s25;
	assign cs = cs_s25;

endmodule

>>> sv/axis_angle_rotation_matrix.sv
// Top level: axis-angle to rotation matrix via a unit quaternion.
// Depends on aar_pkg, aar_norm and aar_sincos.
`timescale 1ns / 1ps
//
// Input channel: axis_x/y/z (Q16.16) and angle_deg (Q10.16 degrees) with
// in_valid/in_ready. Output channel: nine Q2.30 entries r00..r22 row-major
// and axis_ok, with out_valid/out_ready. One result per input transaction,
// in order.
// An accepted input reaches out_valid through the axis path (32 square-root
// stages and 31 divide stages, one bit each), then the quaternion and matrix
// stages and the output register.
// Throughput: one transaction per cycle while enabled. The whole pipeline
// shares one advance enable; it moves whenever its last stage is empty or
// the output register can take that stage's item. While a result waits in
// the output register, new input is still taken until an item reaches the
// last stage. A zero axis yields the identity matrix with axis_ok low.
// Reset clears all valid bits and out_valid; no results are pending after.
//
module axis_angle_rotation_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] axis_x,
	input  logic signed [31:0] axis_y,
	input  logic signed [31:0] axis_z,
	input  logic signed [25:0] angle_deg,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] r00,
	output logic signed [31:0] r01,
	output logic signed [31:0] r02,
	output logic signed [31:0] r10,
	output logic signed [31:0] r11,
	output logic signed [31:0] r12,
	output logic signed [31:0] r20,
	output logic signed [31:0] r21,
	output logic signed [31:0] r22,
	output logic               axis_ok
);

	logic               en;
	aar_pkg::aar_unit_t unit;
	logic signed [25:0] ang_dly_q [0:aar_pkg::ANG_DLY-1];
	logic signed [31:0] sn;
	logic signed [31:0] cs;

	logic [2:0][61:0]   pr_s70;
	logic [2:0]         sg_s70;
	logic signed [31:0] cs_s70;
	logic               ok_s70;
	logic               vld_s70;

	logic signed [31:0] q_s71 [0:3];
	logic               ok_s71;
	logic               vld_s71;

	logic signed [63:0] p00_s72, p11_s72, p22_s72, p01_s72, p02_s72;
	logic signed [63:0] p12_s72, p03_s72, p13_s72, p23_s72;
	logic               ok_s72;
	logic               vld_s72;

	logic signed [63:0] m_s73 [0:8];
	logic               ok_s73;
	logic               vld_s73;

	logic signed [31:0] r_s74 [0:8];
	logic               ok_s74;
	logic               vld_s74;

	logic signed [31:0] r_q [0:8];
	logic               ok_q;
	logic               out_valid_q;

	assign en       = !vld_s74 || !out_valid_q || out_ready;
	assign in_ready = en;

	aar_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (in_valid),
		.axis   ({axis_z, axis_y, axis_x}),
		.res    (unit)
	);

	// angle waits so its sine/cosine meet the normalized axis
	always_ff @(posedge clk) begin
		if (en) begin
			ang_dly_q[0] <= angle_deg;
			for (int j = 1; j < aar_pkg::ANG_DLY; j++) begin
				ang_dly_q[j] <= ang_dly_q[j-1];
			end
		end
	end

	aar_sincos u_sincos (
		.clk   (clk),
		.en    (en),
		.angle (ang_dly_q[aar_pkg::ANG_DLY-1]),
		.sn    (sn),
		.cs    (cs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s70     <= 1'b0;
			vld_s71     <= 1'b0;
			vld_s72     <= 1'b0;
			vld_s73     <= 1'b0;
			vld_s74     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en) begin
				vld_s70 <= unit.vld;
				vld_s71 <= vld_s70;
				vld_s72 <= vld_s71;
				vld_s73 <= vld_s72;
				vld_s74 <= vld_s73;
			end
			if (en && vld_s74) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// quaternion vector part: sign-magnitude product, rounded away from zero
			for (int i = 0; i < 3; i++) begin
				logic [31:0] ua;
				logic [31:0] sa;
				ua = unit.u[i][31] ? (~unit.u[i] + 32'd1) : unit.u[i];
				sa = sn[31] ? 32'(-sn) : 32'(sn);
				pr_s70[i] <= 62'(ua[30:0]) * 62'(sa[30:0]);
				sg_s70[i] <= unit.u[i][31] ^ sn[31];
			end
			cs_s70 <= cs;
			ok_s70 <= unit.ok;

			for (int i = 0; i < 3; i++) begin
				logic [31:0] qm;
				qm = 32'((pr_s70[i] + (62'd1 << 29)) >> 30);
				q_s71[i] <= sg_s70[i] ? -$signed(qm) : $signed(qm);
			end
			q_s71[3] <= cs_s70;
			ok_s71   <= ok_s70;

			p00_s72 <= 64'(q_s71[0]) * 64'(q_s71[0]);
			p11_s72 <= 64'(q_s71[1]) * 64'(q_s71[1]);
			p22_s72 <= 64'(q_s71[2]) * 64'(q_s71[2]);
			p01_s72 <= 64'(q_s71[0]) * 64'(q_s71[1]);
			p02_s72 <= 64'(q_s71[0]) * 64'(q_s71[2]);
			p12_s72 <= 64'(q_s71[1]) * 64'(q_s71[2]);
			p03_s72 <= 64'(q_s71[0]) * 64'(q_s71[3]);
			p13_s72 <= 64'(q_s71[1]) * 64'(q_s71[3]);
			p23_s72 <= 64'(q_s71[2]) * 64'(q_s71[3]);
			ok_s72  <= ok_s71;

			m_s73[0] <= aar_pkg::ONE60 - ((p11_s72 + p22_s72) <<< 1);
			m_s73[1] <= (p01_s72 - p23_s72) <<< 1;
			m_s73[2] <= (p02_s72 + p13_s72) <<< 1;
			m_s73[3] <= (p01_s72 + p23_s72) <<< 1;
			m_s73[4] <= aar_pkg::ONE60 - ((p22_s72 + p00_s72) <<< 1);
			m_s73[5] <= (p12_s72 - p03_s72) <<< 1;
			m_s73[6] <= (p02_s72 - p13_s72) <<< 1;
			m_s73[7] <= (p12_s72 + p03_s72) <<< 1;
			m_s73[8] <= aar_pkg::ONE60 - ((p11_s72 + p00_s72) <<< 1);
			ok_s73   <= ok_s72;

			// Q.60 to Q2.30, halves away from zero, clamped to +/-1
			for (int i = 0; i < 9; i++) begin
				logic [63:0] mg;
				logic [33:0] rm;
				logic [31:0] cm;
				mg = m_s73[i][63] ? 64'(-m_s73[i]) : 64'(m_s73[i]);
				rm = 34'((mg + (64'd1 << 29)) >> 30);
				cm = (rm > 34'(aar_pkg::ONE30_U)) ? aar_pkg::ONE30_U : rm[31:0];
				if (!ok_s73) begin
					r_s74[i] <= (i % 4 == 0) ? $signed(aar_pkg::ONE30_U) : 32'sd0;
				end else begin
					r_s74[i] <= m_s73[i][63] ? -$signed(cm) : $signed(cm);
				end
			end
			ok_s74 <= ok_s73;
		end

		if (en && vld_s74) begin
			r_q  <= r_s74;
			ok_q <= ok_s74;
		end
	end

	assign out_valid = out_valid_q;
	assign r00       = r_q[0];
	assign r01       = r_q[1];
	assign r02       = r_q[2];
	assign r10       = r_q[3];
	assign r11       = r_q[4];
	assign r12       = r_q[5];
	assign r20       = r_q[6];
	assign r21       = r_q[7];
	assign r22       = r_q[8];
	assign axis_ok   = ok_q;

endmodule

>>> tb/tb_axis_angle_rotation_matrix.sv
// Testbench for axis_angle_rotation_matrix: drives axis/angle transactions,
// predicts the Q2.30 rotation matrix in fixed point and checks every result.
// Depends on aar_pkg and the axis_angle_rotation_matrix RTL.
`timescale 1ns / 1ps
module tb_axis_angle_rotation_matrix;

	localparam longint LIMIT = 400000;
	localparam longint TURN = 47185920;
	localparam longint QUARTER = 11796480;
	localparam longint EIGHTH = 5898240;
	localparam longint HALF_TURN = 23592960;

	typedef struct {
		logic signed [31:0] m [9];
		logic ok;
	} rot_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_ready = 0;
	logic signed [31:0] axis_x = 0, axis_y = 0, axis_z = 0;
	logic signed [25:0] angle_deg = 0;
	logic in_ready, out_valid, axis_ok;
	logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

	rot_t pending_rot[$];
	int errors = 0;
	int send_idle = 0, recv_idle = 0;
	int hold_cycles = 0;
	longint cycles = 0;

	axis_angle_rotation_matrix dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic longint rnd_shift(longint v, int n);
		longint h;
		h = longint'(1) << (n - 1);
		if (v < 0)
			return -(((-v) + h) >>> n);
		return (v + h) >>> n;
	endfunction

	function automatic longint clip30(longint v);
		if (v > (longint'(1) << 30)) return longint'(1) << 30;
		if (v < -(longint'(1) << 30)) return -(longint'(1) << 30);
		return v;
	endfunction

	function automatic longint int_sqrt(longint unsigned t);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > t) b >>= 2;
		while (b != 0) begin
			if (t >= res + b) begin
				t -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint taylor(longint unsigned x2, longint unsigned start, int first);
		longint unsigned t;
		longint sum;
		int n;
		t = start;
		sum = start;
		n = first;
		for (int k = 1; k <= 6; k++) begin
			t = ((t * x2) >> 32) / (longint'(n) * (n + 1));
			if (k % 2) sum -= t; else sum += t;
			n += 2;
		end
		if (sum < 0) sum = 0;
		if (sum > (longint'(1) << 32)) sum = longint'(1) << 32;
		return rnd_shift(sum, 2);
	endfunction

	function automatic rot_t predict_rotation(logic signed [31:0] ax, logic signed [31:0] ay,
			logic signed [31:0] az, logic signed [25:0] ang);
		rot_t r;
		longint a[3], u[3], q[4], mm[9];
		longint unsigned mag[3], mx, t, rt, v, xr, x2;
		longint h, rem, s, c, tmp;
		int sh, quad;
		bit swap;
		a[0] = ax; a[1] = ay; a[2] = az;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = a[i] < 0 ? -a[i] : a[i];
			if (mag[i] > mx) mx = mag[i];
		end
		if (mx == 0) begin
			for (int i = 0; i < 9; i++) r.m[i] = (i % 4 == 0) ? 32'sd1 <<< 30 : 32'sd0;
			r.ok = 0;
			return r;
		end
		sh = 0;
		while ((mx << sh) < (64'd1 << 30)) sh++;
		t = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] <<= sh;
			t += mag[i] * mag[i];
		end
		rt = int_sqrt(t);
		for (int i = 0; i < 3; i++) begin
			v = ((mag[i] << 30) + (rt >> 1)) / rt;
			if (v > (64'd1 << 30)) v = 64'd1 << 30;
			u[i] = a[i] < 0 ? -longint'(v) : longint'(v);
		end
		h = longint'(ang) % TURN;
		if (h < 0) h += TURN;
		quad = h / QUARTER;
		rem = h - quad * QUARTER;
		swap = 0;
		if (rem > EIGHTH) begin
			rem = QUARTER - rem;
			swap = 1;
		end
		xr = (longint'(rem) * aar_pkg::DEG2RAD_Q46 + (64'd1 << 30)) >> 31;
		x2 = (xr * xr + (64'd1 << 31)) >> 32;
		s = taylor(x2, xr, 2);
		c = taylor(x2, 64'd1 << 32, 1);
		if (swap) begin
			tmp = s; s = c; c = tmp;
		end
		case (quad)
			1: begin tmp = s; s = c; c = -tmp; end
			2: begin s = -s; c = -c; end
			3: begin tmp = s; s = -c; c = tmp; end
			default: ;
		endcase
		for (int i = 0; i < 3; i++) q[i] = rnd_shift(u[i] * s, 30);
		q[3] = c;
		mm[0] = aar_pkg::ONE60 - 2 * (q[1] * q[1] + q[2] * q[2]);
		mm[1] = 2 * (q[0] * q[1] - q[2] * q[3]);
		mm[2] = 2 * (q[2] * q[0] + q[1] * q[3]);
		mm[3] = 2 * (q[0] * q[1] + q[2] * q[3]);
		mm[4] = aar_pkg::ONE60 - 2 * (q[2] * q[2] + q[0] * q[0]);
		mm[5] = 2 * (q[1] * q[2] - q[0] * q[3]);
		mm[6] = 2 * (q[2] * q[0] - q[1] * q[3]);
		mm[7] = 2 * (q[1] * q[2] + q[0] * q[3]);
		mm[8] = aar_pkg::ONE60 - 2 * (q[1] * q[1] + q[0] * q[0]);
		for (int i = 0; i < 9; i++) r.m[i] = clip30(rnd_shift(mm[i], 30));
		r.ok = 1;
		return r;
	endfunction

	// receiver: random stalls, plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 0;
		end else
			out_ready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		rot_t e;
		logic signed [31:0] got [9];
		if (arst_n && out_valid && out_ready) begin
			got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
			if (pending_rot.size() == 0) begin
				$error("result with no pending transaction");
				errors++;
			end else begin
				e = pending_rot.pop_front();
				for (int i = 0; i < 9; i++)
					if (got[i] !== e.m[i]) begin
						$error("r%0d%0d: expected %0d got %0d", i / 3, i % 3, e.m[i], got[i]);
						errors++;
					end
				if (axis_ok !== e.ok) begin
					$error("axis_ok: expected %0b got %0b", e.ok, axis_ok);
					errors++;
				end
			end
		end
	end

	// valid stays up between back-to-back transactions; it drops only while idling
	task automatic send_rot(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic signed [25:0] ang);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		axis_x <= x;
		axis_y <= y;
		axis_z <= z;
		angle_deg <= ang;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_rot.push_back(predict_rotation(x, y, z, ang));
	endtask

	function automatic logic signed [25:0] rnd_angle();
		case ($urandom_range(3))
			0: return $urandom_range(2 * HALF_TURN) - HALF_TURN;
			1: return $urandom_range(32) * EIGHTH / 2 - HALF_TURN + $urandom_range(2) - 1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] rnd_comp();
		case ($urandom_range(5))
			0: return 0;
			1: return $urandom_range(3) - 1;
			2: return $signed($urandom) >>> $urandom_range(31);
			3: return 32'h80000000;
			default: return $urandom;
		endcase
	endfunction

	task automatic drain_results();
		in_valid <= 0;
		while (pending_rot.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		logic signed [25:0] angs [12] = '{0, 26'sd5898240, 26'sd11796480, 26'sd23592960,
			-26'sd23592960, -26'sd5898240, 26'sd17694720, 26'sd1, -26'sd1,
			26'h1FFFFFF, 26'h2000000, 26'sd8847360};
		send_rot(0, 0, 0, 26'sd5898240);
		send_rot(0, 0, 0, 0);
		foreach (angs[i]) send_rot(32'sd65536, 0, 0, angs[i]);
		send_rot(32'h80000000, 32'h80000000, 32'h80000000, 26'sd2949120);
		send_rot(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, -26'sd2949120);
		send_rot(0, 0, 1, 26'sd5898240);
		send_rot(0, -1, 0, 26'sd5898240);
		send_rot(32'h7FFFFFFF, 32'h80000000, 1, 26'h1FFFFFF);
		send_rot(-1, -1, -1, 26'h2000000);
		send_rot(32'hFFFFFFFF, 0, 32'h55555555, 26'h2AAAAAA);
		send_rot(32'hAAAAAAAA, 32'h55555555, 0, 26'h1555555);
		drain_results();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_rot(rnd_comp(), rnd_comp(), rnd_comp(), rnd_angle());
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		for (int i = 0; i < 150; i++)
			send_rot(rnd_comp(), rnd_comp(), rnd_comp(), rnd_angle());
		drain_results();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		send_idle = 8; recv_idle = 50;
		test_random(350);
		drain_results();
		send_idle = 50; recv_idle = 8;
		test_random(300);
		send_idle = 0; recv_idle = 0;
		test_random(300);
		test_backpressure();
		drain_results();
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_rot.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
